>>> rtl/nlp_pkg.sv
package nlp_pkg;

	typedef struct packed {
		logic [7:0] ch;
		logic       end_of_text;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] status;
		logic       last_byte;
	} out_word_t;

	typedef struct packed {
		logic [31:0] acc;
		logic        neg;
		logic        ovf;
		logic        bad;
	} lit_t;

	typedef struct packed {
		logic avail;
		logic full;
	} q_stat_t;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_CHAR = 2'd1;
	localparam logic [1:0] ST_TOO_BIG  = 2'd2;
	localparam logic [1:0] ST_TOO_LOW  = 2'd3;

	localparam logic [1:0] TYPE_BYTE = 2'd0;
	localparam logic [1:0] TYPE_WORD = 2'd1;
	localparam logic [1:0] TYPE_LONG = 2'd2;

	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_LO_F   = 8'h66;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_F   = 8'h46;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_HYPHEN = 8'h2D;

	localparam logic [31:0] HEX_OVF_LIM = 32'h1000_0000;
	localparam logic [31:0] DEC_OVF_LIM = 32'd429496729;

	localparam logic [31:0] NMAX_BYTE = 32'd128;
	localparam logic [31:0] NMAX_WORD = 32'd32768;
	localparam logic [31:0] NMAX_LONG = 32'h8000_0000;

endpackage

>>> rtl/nlp_front.sv
module nlp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  nlp_pkg::in_word_t in_data,
	input  nlp_pkg::q_stat_t  q_stat,
	output logic              push,
	output nlp_pkg::lit_t     push_data
);

	logic [31:0] acc_q;
	logic [1:0]  pos_q;
	logic        hex_q;
	logic        neg_q;
	logic        ovf_q;
	logic        bad_q;

	logic        is_dec;
	logic        is_letter;
	logic        digit_ok;
	logic [3:0]  d;
	logic        is_prefix;
	logic        is_minus;
	logic [31:0] acc_d;
	logic        hex_d;
	logic        neg_d;
	logic        ovf_d;
	logic        bad_d;
	logic        take;

	assign in_ready = !q_stat.full;
	assign take     = in_valid && in_ready;
	assign push     = take && in_data.end_of_text;

	always_comb begin
		is_dec    = (in_data.ch >= nlp_pkg::CH_ZERO) && (in_data.ch <= nlp_pkg::CH_NINE);
		is_letter = hex_q &&
			(((in_data.ch >= nlp_pkg::CH_LO_A) && (in_data.ch <= nlp_pkg::CH_LO_F)) ||
			 ((in_data.ch >= nlp_pkg::CH_UP_A) && (in_data.ch <= nlp_pkg::CH_UP_F)));
		digit_ok  = is_dec || is_letter;
		d         = is_dec ? in_data.ch[3:0] : in_data.ch[3:0] + 4'd9;
		is_prefix = (in_data.ch == nlp_pkg::CH_X) && (pos_q == 2'd1) && !hex_q && !neg_q &&
			!bad_q && (acc_q == 32'd0);
		is_minus  = (in_data.ch == nlp_pkg::CH_HYPHEN) &&
			((!hex_q && (pos_q == 2'd0)) || (hex_q && (pos_q == 2'd2)));

		acc_d = acc_q;
		hex_d = hex_q;
		neg_d = neg_q;
		ovf_d = ovf_q;
		bad_d = bad_q;
		if (is_prefix) begin
			hex_d = 1'b1;
		end else if (is_minus) begin
			neg_d = 1'b1;
		end else if (!digit_ok) begin
			bad_d = 1'b1;
		end else if (hex_q) begin
			if (acc_q >= nlp_pkg::HEX_OVF_LIM)
				ovf_d = 1'b1;
			acc_d = {acc_q[27:0], d};
		end else begin
			if ((acc_q > nlp_pkg::DEC_OVF_LIM) ||
			    ((acc_q == nlp_pkg::DEC_OVF_LIM) && (d > 4'd5)))
				ovf_d = 1'b1;
			acc_d = {acc_q[28:0], 3'b000} + {acc_q[30:0], 1'b0} + {28'd0, d};
		end
	end

	assign push_data = '{acc: acc_d, neg: neg_d, ovf: ovf_d, bad: bad_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			pos_q <= '0;
			hex_q <= 1'b0;
			neg_q <= 1'b0;
			ovf_q <= 1'b0;
			bad_q <= 1'b0;
		end else if (take) begin
			if (in_data.end_of_text) begin
				acc_q <= '0;
				pos_q <= '0;
				hex_q <= 1'b0;
				neg_q <= 1'b0;
				ovf_q <= 1'b0;
				bad_q <= 1'b0;
			end else begin
				acc_q <= acc_d;
				hex_q <= hex_d;
				neg_q <= neg_d;
				ovf_q <= ovf_d;
				bad_q <= bad_d;
				if (pos_q != 2'd3)
					pos_q <= pos_q + 2'd1;
			end
		end
	end

endmodule

>>> rtl/nlp_queue.sv
module nlp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  nlp_pkg::lit_t    push_data,
	input  logic             pop,
	output nlp_pkg::lit_t    head,
	output nlp_pkg::q_stat_t q_stat
);

	nlp_pkg::lit_t mem_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	assign head         = mem_q[rd_ptr_q];
	assign q_stat.avail = (count_q != 2'd0);
	assign q_stat.full  = (count_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

endmodule

>>> rtl/nlp_back.sv
module nlp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         value_type,
	input  nlp_pkg::lit_t      head,
	input  nlp_pkg::q_stat_t   q_stat,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output nlp_pkg::out_word_t out_data
);

	logic [1:0]         k_q;
	logic               out_valid_q;
	nlp_pkg::out_word_t out_q;

	logic [1:0]         last_idx;
	logic               too_big_u;
	logic [31:0]        nmax;
	logic [1:0]         status;
	logic [31:0]        v;
	logic [7:0]         b;
	logic               is_last;
	logic               load;

	always_comb begin
		unique case (value_type)
			nlp_pkg::TYPE_BYTE: begin
				last_idx  = 2'd0;
				too_big_u = (head.acc[31:8] != 24'd0);
				nmax      = nlp_pkg::NMAX_BYTE;
			end
			nlp_pkg::TYPE_WORD: begin
				last_idx  = 2'd1;
				too_big_u = (head.acc[31:16] != 16'd0);
				nmax      = nlp_pkg::NMAX_WORD;
			end
			default: begin
				last_idx  = 2'd3;
				too_big_u = 1'b0;
				nmax      = nlp_pkg::NMAX_LONG;
			end
		endcase

		priority if (head.bad)
			status = nlp_pkg::ST_BAD_CHAR;
		else if (head.ovf)
			status = nlp_pkg::ST_TOO_BIG;
		else if (head.neg && (head.acc > nmax))
			status = nlp_pkg::ST_TOO_LOW;
		else if (!head.neg && too_big_u)
			status = nlp_pkg::ST_TOO_BIG;
		else
			status = nlp_pkg::ST_OK;

		v = head.neg ? (~head.acc + 32'd1) : head.acc;
		unique case (k_q)
			2'd0:    b = v[7:0];
			2'd1:    b = v[15:8];
			2'd2:    b = v[23:16];
			default: b = v[31:24];
		endcase

		if (status != nlp_pkg::ST_OK) begin
			b       = 8'd0;
			is_last = 1'b1;
		end else begin
			is_last = (k_q == last_idx);
		end
	end

	assign load      = q_stat.avail && (!out_valid_q || out_ready);
	assign pop       = load && is_last;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		if (load)
			out_q <= '{out_byte: b, status: status, last_byte: is_last};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			k_q         <= '0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (load)
				k_q <= is_last ? 2'd0 : k_q + 2'd1;
		end
	end

endmodule

>>> rtl/numeric_literal_parser_unit.sv
// channel | direction | word                            | handshake
// in      | input     | ch, end_of_text                 | in_valid / in_ready
// out     | output    | out_byte, status, last_byte     | out_valid / out_ready
// cfg     | input     | value_type (2 bits)             | cfg_valid / cfg_ready
//
// One character is taken per cycle while the two-entry literal queue has room.
// The final character of a literal enters the queue at its accepting edge; the
// back end then loads result words from the queue head into the output register,
// one per cycle unless out stalls: 1, 2 or 4 bytes, or one error word.
// Reset clears the digit state, the queue and the output valid flag; value_type
// returns to long. Out stalls hold the output register and, once the queue is
// full, in_ready falls. cfg_ready is always high.
module numeric_literal_parser_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  nlp_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output nlp_pkg::out_word_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_data
);

	logic [1:0]       value_type_q;
	logic             push;
	logic             pop;
	nlp_pkg::lit_t    push_data;
	nlp_pkg::lit_t    head;
	nlp_pkg::q_stat_t q_stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			value_type_q <= nlp_pkg::TYPE_LONG;
		else if (cfg_valid)
			value_type_q <= cfg_data;
	end

	nlp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	nlp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	nlp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.value_type (value_type_q),
		.head       (head),
		.q_stat     (q_stat),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

>>> tb/sv/numeric_literal_parser_unit_test.sv
`timescale 1ns / 100ps

module numeric_literal_parser_unit_test;

	class literal_scoreboard;
		logic [1:0]  value_type;
		logic [31:0] acc;
		logic [1:0]  pos;
		bit          hex, neg, ovf, bad;
		nlp_pkg::out_word_t expected[$];
		int          fails;

		function new();
			value_type = nlp_pkg::TYPE_LONG;
			fails = 0;
			clear();
		endfunction

		function void clear();
			acc = '0;
			pos = '0;
			hex = 0;
			neg = 0;
			ovf = 0;
			bad = 0;
		endfunction

		function void note_input(nlp_pkg::in_word_t w);
			logic [7:0]  c;
			logic [3:0]  d;
			bit          ok;
			logic [31:0] umax, nmax, v;
			int          nbytes;
			c = w.ch;
			ok = 1;
			d = '0;
			if (c == nlp_pkg::CH_X && pos == 2'd1 && !hex && !neg && !bad && acc == 0) begin
				hex = 1;
			end else if (c == nlp_pkg::CH_HYPHEN &&
				((!hex && pos == 2'd0) || (hex && pos == 2'd2))) begin
				neg = 1;
			end else begin
				if (c >= nlp_pkg::CH_ZERO && c <= nlp_pkg::CH_NINE)
					d = 4'(c - nlp_pkg::CH_ZERO);
				else if (hex && c >= nlp_pkg::CH_LO_A && c <= nlp_pkg::CH_LO_F)
					d = 4'(c - nlp_pkg::CH_LO_A + 8'd10);
				else if (hex && c >= nlp_pkg::CH_UP_A && c <= nlp_pkg::CH_UP_F)
					d = 4'(c - nlp_pkg::CH_UP_A + 8'd10);
				else
					ok = 0;
				if (!ok) begin
					bad = 1;
				end else if (hex) begin
					if (acc >= nlp_pkg::HEX_OVF_LIM)
						ovf = 1;
					acc = {acc[27:0], d};
				end else begin
					if (acc > nlp_pkg::DEC_OVF_LIM ||
						(acc == nlp_pkg::DEC_OVF_LIM && d > 4'd5))
						ovf = 1;
					acc = acc * 32'd10 + {28'd0, d};
				end
			end
			if (pos != 2'd3)
				pos = pos + 2'd1;
			if (!w.end_of_text)
				return;
			case (value_type)
				nlp_pkg::TYPE_BYTE: begin
					nbytes = 1; umax = 32'hFF; nmax = nlp_pkg::NMAX_BYTE;
				end
				nlp_pkg::TYPE_WORD: begin
					nbytes = 2; umax = 32'hFFFF; nmax = nlp_pkg::NMAX_WORD;
				end
				default: begin
					nbytes = 4; umax = 32'hFFFF_FFFF; nmax = nlp_pkg::NMAX_LONG;
				end
			endcase
			if (bad)
				expected.push_back(nlp_pkg::out_word_t'{out_byte: 8'h00,
					status: nlp_pkg::ST_BAD_CHAR, last_byte: 1'b1});
			else if (ovf)
				expected.push_back(nlp_pkg::out_word_t'{out_byte: 8'h00,
					status: nlp_pkg::ST_TOO_BIG, last_byte: 1'b1});
			else if (neg && acc > nmax)
				expected.push_back(nlp_pkg::out_word_t'{out_byte: 8'h00,
					status: nlp_pkg::ST_TOO_LOW, last_byte: 1'b1});
			else if (!neg && acc > umax)
				expected.push_back(nlp_pkg::out_word_t'{out_byte: 8'h00,
					status: nlp_pkg::ST_TOO_BIG, last_byte: 1'b1});
			else begin
				v = neg ? ~acc + 32'd1 : acc;
				for (int k = 0; k < nbytes; k++)
					expected.push_back(nlp_pkg::out_word_t'{out_byte: v[8*k +: 8],
						status: nlp_pkg::ST_OK, last_byte: (k == nbytes - 1)});
			end
			clear();
		endfunction

		function void check_result(nlp_pkg::out_word_t got);
			nlp_pkg::out_word_t want;
			if (expected.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %h/%0d/%0d", $time,
					got.out_byte, got.status, got.last_byte);
				fails++;
				return;
			end
			want = expected.pop_front();
			if (got.out_byte !== want.out_byte) begin
				$display("%0t: out_byte expected %h actual %h", $time, want.out_byte, got.out_byte);
				fails++;
			end
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
				fails++;
			end
			if (got.last_byte !== want.last_byte) begin
				$display("%0t: last_byte expected %0d actual %0d", $time, want.last_byte,
					got.last_byte);
				fails++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	nlp_pkg::in_word_t  in_data;
	logic               out_valid;
	logic               out_ready;
	nlp_pkg::out_word_t out_data;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_data;

	bit                calm;
	logic [7:0]        text[$];
	literal_scoreboard book;

	numeric_literal_parser_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#400000;
		$display("FAIL numeric_literal_parser_unit");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			book.check_result(out_data);
		out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 7);
	end

	task automatic put_char(input nlp_pkg::in_word_t w);
		if (!calm && $urandom_range(99) < 5) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		book.note_input(w);
	endtask

	task automatic send_literal();
		foreach (text[i])
			put_char(nlp_pkg::in_word_t'{ch: text[i], end_of_text: (i == text.size() - 1)});
	endtask

	task automatic send_string(input string s);
		text.delete();
		for (int i = 0; i < s.len(); i++)
			text.push_back(s[i]);
		send_literal();
	endtask

	task automatic write_type(input logic [1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		book.value_type = v;
		cfg_valid <= 1'b0;
	endtask

	// drain the block before touching the type register
	task automatic settle();
		in_valid <= 1'b0;
		while (book.expected.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [7:0] odd_char();
		case ($urandom_range(15))
			0: return 8'h2F;
			1: return 8'h3A;
			2: return 8'h40;
			3: return 8'h41;
			4: return 8'h46;
			5: return 8'h47;
			6: return 8'h60;
			7: return 8'h61;
			8: return 8'h66;
			9: return 8'h67;
			10: return nlp_pkg::CH_X;
			11: return 8'h58;
			12: return nlp_pkg::CH_HYPHEN;
			13: return nlp_pkg::CH_ZERO;
			14: return 8'h00;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic longint unsigned pick_value();
		case ($urandom_range(9))
			0, 1, 2: begin
				case ($urandom_range(17))
					0: return 64'd0;
					1: return 64'd1;
					2: return 64'd127;
					3: return 64'd128;
					4: return 64'd129;
					5: return 64'd255;
					6: return 64'd256;
					7: return 64'd32767;
					8: return 64'd32768;
					9: return 64'd32769;
					10: return 64'd65535;
					11: return 64'd65536;
					12: return 64'h7FFF_FFFF;
					13: return 64'h8000_0000;
					14: return 64'h8000_0001;
					15: return 64'hFFFF_FFFF;
					16: return 64'h1_0000_0000;
					default: return 64'd42949672955;
				endcase
			end
			3, 4: return longint'($urandom_range(300));
			5, 6: return longint'($urandom_range(70000));
			7, 8: return longint'($urandom);
			default: return {$urandom, $urandom} >> $urandom_range(31);
		endcase
	endfunction

	function automatic void push_dec(input longint unsigned v);
		logic [7:0] d[$];
		do begin
			d.push_front(nlp_pkg::CH_ZERO + 8'(v % 10));
			v = v / 10;
		end while (v != 0);
		foreach (d[i])
			text.push_back(d[i]);
	endfunction

	function automatic void push_hex(input longint unsigned v);
		logic [7:0] d[$];
		logic [3:0] n;
		do begin
			n = v[3:0];
			if (n < 4'd10)
				d.push_front(nlp_pkg::CH_ZERO + n);
			else
				d.push_front(($urandom_range(1) ? nlp_pkg::CH_UP_A : nlp_pkg::CH_LO_A) +
					n - 8'd10);
			v = v >> 4;
		end while (v != 0);
		foreach (d[i])
			text.push_back(d[i]);
	endfunction

	function automatic void make_literal();
		int              kind;
		int              at;
		bit              hexa, minus;
		longint unsigned v;
		text.delete();
		kind = $urandom_range(99);
		if (kind < 12) begin
			repeat ($urandom_range(1, 5)) text.push_back(odd_char());
			return;
		end
		hexa = $urandom_range(99) < 40;
		minus = $urandom_range(99) < 30;
		v = pick_value();
		if (hexa) begin
			text.push_back(nlp_pkg::CH_ZERO);
			text.push_back(nlp_pkg::CH_X);
		end
		if (minus)
			text.push_back(nlp_pkg::CH_HYPHEN);
		if ($urandom_range(9) == 0)
			text.push_back(nlp_pkg::CH_ZERO);
		if (hexa)
			push_hex(v);
		else
			push_dec(v);
		if (kind < 25) begin
			at = $urandom_range(text.size() - 1);
			if ($urandom_range(1))
				text[at] = odd_char();
			else
				text.insert(at, odd_char());
		end
	endfunction

	task automatic random_phase(input logic [1:0] vt, input bit quiet, input int chars);
		int sent;
		sent = 0;
		write_type(vt);
		calm <= quiet;
		while (sent < chars) begin
			make_literal();
			send_literal();
			sent += text.size();
		end
		settle();
	endtask

	initial begin
		book = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = nlp_pkg::TYPE_LONG;
		calm = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_type(nlp_pkg::TYPE_LONG);
		send_string("-");
		send_string("0x");
		send_string("0x-");
		send_string("0X1");
		send_string("1x");
		send_string("0xaF");
		send_string("4294967296");
		text.delete();
		text.push_back(8'h00);
		send_literal();
		settle();

		random_phase(nlp_pkg::TYPE_BYTE, 1'b0, 85);
		random_phase(nlp_pkg::TYPE_WORD, 1'b0, 85);
		random_phase(nlp_pkg::TYPE_LONG, 1'b0, 85);
		random_phase(2'd3, 1'b0, 80);
		random_phase(nlp_pkg::TYPE_BYTE, 1'b1, 80);
		random_phase(nlp_pkg::TYPE_WORD, 1'b0, 80);

		if (book.fails == 0 && book.expected.size() == 0)
			$display("PASS numeric_literal_parser_unit");
		else
			$display("FAIL numeric_literal_parser_unit");
		$finish;
	end

endmodule
